### rtl/core/two_axis_stepper_seek_controller_top_defines.svh
// Assertion macros for the two-axis stepper seek controller.
// Included by the checker; depends on nothing else.
`ifndef TWO_AXIS_STEPPER_SEEK_CONTROLLER_TOP_DEFINES_SVH
`define TWO_AXIS_STEPPER_SEEK_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TSSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define TSSC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tssc_pkg.sv
// Shared types, widths and the coil table of the two-axis stepper controller.
// No dependencies.
package tssc_pkg;

   // field widths of the request and result channels
   localparam int unsigned POS_W   = 8;
   localparam int unsigned DELAY_W = 24;
   localparam int unsigned COIL_W  = 4;

   // request operation codes
   typedef enum logic [1:0] {
      OP_TICK     = 2'd0,
      OP_STEP_CW  = 2'd1,
      OP_STEP_CCW = 2'd2,
      OP_SEEK     = 2'd3
   } op_type;

   typedef logic [1:0]        phase_type;
   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [COIL_W-1:0] coil_type;

   // full-step coil pattern for each phase (A A' B B')
   function automatic coil_type coil_pattern(input phase_type phase);
      coil_type pat;
      unique case (phase)
         2'd0:    pat = 4'd10;
         2'd1:    pat = 4'd9;
         2'd2:    pat = 4'd5;
         default: pat = 4'd6;
      endcase
      return pat;
   endfunction

endpackage

### rtl/core/tssc_if.sv
// Request and result channel interfaces of the two-axis stepper controller.
// Depends on tssc_pkg.
interface tssc_req_if;
   import tssc_pkg::*;

   logic                 valid;
   logic                 ready;
   op_type               op;
   logic                 axis;
   logic [POS_W-1:0]     target;
   logic [DELAY_W-1:0]   delay;

   modport source (output valid, output op, output axis, output target, output delay,
                   input ready);
   modport sink   (input valid, input op, input axis, input target, input delay,
                   output ready);
endinterface

interface tssc_rsp_if;
   import tssc_pkg::*;

   logic                valid;
   logic                ready;
   logic [COIL_W-1:0]   coils_x;
   logic [COIL_W-1:0]   coils_y;
   logic [POS_W-1:0]    pos_x;
   logic [POS_W-1:0]    pos_y;
   logic                busy_res;

   modport source (output valid, output coils_x, output coils_y, output pos_x,
                   output pos_y, output busy_res, input ready);
   modport sink   (input valid, input coils_x, input coils_y, input pos_x,
                   input pos_y, input busy_res, output ready);
endinterface

### rtl/core/two_axis_stepper_seek_controller_top.sv
// Two-axis full-step stepper sequencer with horizontal seek, top level.
// Depends on tssc_pkg and the channel interfaces in tssc_if.sv.
//
// Usage:
//   req_chan carries one request per handshake: a tick, a single clockwise or
//   counterclockwise step of either axis, or the start of a horizontal seek
//   with a target and a per-step tick delay. rsp_chan returns exactly one
//   result per request: both coil patterns, both shaft positions and the
//   seek busy flag, all taken after the request's update.
//   The result is registered and valid the cycle after the request is
//   accepted. Throughput is one request per cycle while the receiver takes
//   each result; state update and result register load at the same edge.
//   While a result waits, req_chan.ready follows rsp_chan.ready, so a stalled
//   receiver holds the result stable and blocks new requests, nothing is lost.
//   Seek steps are paced by tick requests only, delay+1 ticks apart.
//   Synchronous reset clears all positions, phases, coil drives and the seek
//   state; the result register comes up empty.
module two_axis_stepper_seek_controller_top #(
   parameter int unsigned STEPS_PER_REV = 200,
   parameter int unsigned DELAY_BITS    = 24
) (
   input  logic        clock,
   input  logic        reset,
   tssc_req_if.sink    req_chan,
   tssc_rsp_if.source  rsp_chan
);
   import tssc_pkg::*;

   localparam pos_type    LAST_POS  = POS_W'(STEPS_PER_REV - 1);
   localparam logic [8:0] STEPS_W9  = 9'(STEPS_PER_REV);
   localparam logic [8:0] HALF_REV  = 9'(STEPS_PER_REV / 2);

   typedef logic [DELAY_BITS-1:0] wait_type;

   // axis state
   phase_type phase_x_ff, phase_x_in, phase_y_ff, phase_y_in;
   pos_type   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   coil_type  drive_x_ff, drive_x_in, drive_y_ff, drive_y_in;

   // seek state
   logic      seeking_ff, seeking_in;
   logic      seek_ccw_ff, seek_ccw_in;
   pos_type   seek_goal_ff, seek_goal_in;
   wait_type  wait_left_ff, wait_left_in;
   wait_type  step_wait_ff, step_wait_in;

   // result register
   logic      rsp_valid_ff, rsp_valid_in;
   coil_type  rsp_coils_x_ff, rsp_coils_y_ff;
   pos_type   rsp_pos_x_ff, rsp_pos_y_ff;
   logic      rsp_busy_ff;

   logic      req_ready;
   logic      accept;
   logic      move_x, move_y, dir_x_ccw, dir_y_ccw;
   pos_type   goal;
   logic [8:0] cw_dist;
   logic      goal_ccw;
   wait_type  delay_cut;

   // next shaft position, wrapping in both directions
   function automatic pos_type next_pos(input pos_type pos, input logic ccw);
      pos_type res;
      if (ccw) begin
         res = (pos == '0) ? LAST_POS : pos - 1'b1;
      end else begin
         res = (pos >= LAST_POS) ? '0 : pos + 1'b1;
      end
      return res;
   endfunction

   // accept while the result slot is free or being drained
   assign req_ready      = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   // saturate the seek target and pick the shorter direction
   assign delay_cut = DELAY_BITS'(req_chan.delay);
   assign goal      = ({1'b0, req_chan.target} >= STEPS_W9) ? LAST_POS : req_chan.target;
   assign cw_dist   = (goal >= pos_x_ff) ? ({1'b0, goal} - {1'b0, pos_x_ff})
                                         : ({1'b0, goal} + STEPS_W9 - {1'b0, pos_x_ff});
   assign goal_ccw  = (cw_dist > HALF_REV);

   // decide what this request does to the seek state and which axis moves
   always_comb begin
      seeking_in   = seeking_ff;
      seek_ccw_in  = seek_ccw_ff;
      seek_goal_in = seek_goal_ff;
      wait_left_in = wait_left_ff;
      step_wait_in = step_wait_ff;
      move_x       = 1'b0;
      move_y       = 1'b0;
      dir_x_ccw    = seek_ccw_ff;
      dir_y_ccw    = 1'b0;
      if (req_chan.op == OP_TICK) begin
         if (seeking_ff) begin
            if (wait_left_ff != '0) begin
               wait_left_in = wait_left_ff - 1'b1;
            end else if (pos_x_ff == seek_goal_ff) begin
               seeking_in = 1'b0;
            end else begin
               move_x       = 1'b1;
               wait_left_in = step_wait_ff;
            end
         end
      end else if (!seeking_ff) begin
         unique case (req_chan.op)
            OP_STEP_CW, OP_STEP_CCW: begin
               if (req_chan.axis) begin
                  move_y    = 1'b1;
                  dir_y_ccw = (req_chan.op == OP_STEP_CCW);
               end else begin
                  move_x    = 1'b1;
                  dir_x_ccw = (req_chan.op == OP_STEP_CCW);
               end
            end
            default: begin
               if (goal != pos_x_ff) begin
                  seek_goal_in = goal;
                  seek_ccw_in  = goal_ccw;
                  step_wait_in = delay_cut;
                  wait_left_in = delay_cut;
                  seeking_in   = 1'b1;
                  move_x       = 1'b1;
                  dir_x_ccw    = goal_ccw;
               end
            end
         endcase
      end
   end

   // advance the moving axes one full step
   always_comb begin
      phase_x_in = phase_x_ff;
      pos_x_in   = pos_x_ff;
      drive_x_in = drive_x_ff;
      phase_y_in = phase_y_ff;
      pos_y_in   = pos_y_ff;
      drive_y_in = drive_y_ff;
      if (move_x) begin
         phase_x_in = dir_x_ccw ? phase_x_ff - 1'b1 : phase_x_ff + 1'b1;
         pos_x_in   = next_pos(pos_x_ff, dir_x_ccw);
         drive_x_in = coil_pattern(phase_x_in);
      end
      if (move_y) begin
         phase_y_in = dir_y_ccw ? phase_y_ff - 1'b1 : phase_y_ff + 1'b1;
         pos_y_in   = next_pos(pos_y_ff, dir_y_ccw);
         drive_y_in = coil_pattern(phase_y_in);
      end
   end

   // hold the result until taken, load a new one on each request
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_x_ff   <= '0;
         phase_y_ff   <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         drive_x_ff   <= '0;
         drive_y_ff   <= '0;
         seeking_ff   <= 1'b0;
         seek_ccw_ff  <= 1'b0;
         seek_goal_ff <= '0;
         wait_left_ff <= '0;
         step_wait_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_x_ff   <= phase_x_in;
            phase_y_ff   <= phase_y_in;
            pos_x_ff     <= pos_x_in;
            pos_y_ff     <= pos_y_in;
            drive_x_ff   <= drive_x_in;
            drive_y_ff   <= drive_y_in;
            seeking_ff   <= seeking_in;
            seek_ccw_ff  <= seek_ccw_in;
            seek_goal_ff <= seek_goal_in;
            wait_left_ff <= wait_left_in;
            step_wait_ff <= step_wait_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_coils_x_ff <= drive_x_in;
         rsp_coils_y_ff <= drive_y_in;
         rsp_pos_x_ff   <= pos_x_in;
         rsp_pos_y_ff   <= pos_y_in;
         rsp_busy_ff    <= seeking_in;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.coils_x  = rsp_coils_x_ff;
   assign rsp_chan.coils_y  = rsp_coils_y_ff;
   assign rsp_chan.pos_x    = rsp_pos_x_ff;
   assign rsp_chan.pos_y    = rsp_pos_y_ff;
   assign rsp_chan.busy_res = rsp_busy_ff;

endmodule

### rtl/core/tssc_checker.sv
// Port-level checker for the two-axis stepper controller, bound to the top.
// Depends on tssc_pkg and the assertion macros header.
`include "two_axis_stepper_seek_controller_top_defines.svh"

module tssc_checker #(
   parameter int unsigned STEPS_PER_REV = 200
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [tssc_pkg::COIL_W-1:0] rsp_coils_x,
   input logic [tssc_pkg::COIL_W-1:0] rsp_coils_y,
   input logic [tssc_pkg::POS_W-1:0]  rsp_pos_x,
   input logic [tssc_pkg::POS_W-1:0]  rsp_pos_y
);
   import tssc_pkg::*;

   localparam logic [8:0] STEPS_W9 = 9'(STEPS_PER_REV);

   // a stalled result keeps its payload
   `TSSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_coils_x)
      && $stable(rsp_coils_y), "stalled result changed")

   // shaft positions stay inside one revolution
   `TSSC_ASSERT_NOW(a_pos_range, clock, reset, rsp_valid,
      ({1'b0, rsp_pos_x} < STEPS_W9) && ({1'b0, rsp_pos_y} < STEPS_W9),
      "shaft position out of range")

   // horizontal coil drive is off or a valid full-step pattern
   `TSSC_ASSERT_NOW(a_coil_x, clock, reset, rsp_valid,
      rsp_coils_x == 4'd0 || rsp_coils_x == 4'd10 || rsp_coils_x == 4'd9
      || rsp_coils_x == 4'd5 || rsp_coils_x == 4'd6, "bad horizontal coil pattern")

   // reset empties the result register
   `TSSC_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid,
      "result valid after reset")

endmodule

bind two_axis_stepper_seek_controller_top tssc_checker #(
   .STEPS_PER_REV (STEPS_PER_REV)
) u_tssc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_coils_x (rsp_chan.coils_x),
   .rsp_coils_y (rsp_chan.coils_y),
   .rsp_pos_x   (rsp_chan.pos_x),
   .rsp_pos_y   (rsp_chan.pos_y)
);
